// ----- design/arx_pkg.sv -----
package arx_pkg;

    localparam int MAX_A_TAPS   = 8;
    localparam int MAX_B_TAPS   = 8;
    localparam int MAX_DELAY    = 16;
    localparam int SAMPLE_W     = 32;
    localparam int FRAC_BITS    = 16;

    localparam int A_IDX_W      = (MAX_A_TAPS > 1) ? $clog2(MAX_A_TAPS) : 1;
    localparam int B_IDX_W      = (MAX_B_TAPS > 1) ? $clog2(MAX_B_TAPS) : 1;
    localparam int DL_IDX_W     = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int MAX_TAPS     = (MAX_A_TAPS > MAX_B_TAPS) ? MAX_A_TAPS : MAX_B_TAPS;
    localparam int TAP_CNT_W    = $clog2(MAX_TAPS + 1);
    localparam int PROD_W       = 2 * SAMPLE_W;
    localparam int ACC_W        = PROD_W + $clog2(MAX_A_TAPS + MAX_B_TAPS) + 1;
    localparam int SHIFTED_W    = ACC_W - FRAC_BITS;

    localparam int CMD_W        = 3;
    localparam int COEF_IDX_W   = 3;
    localparam int CLAMP_EN_W   = 2;
    localparam int DELAY_W      = 5;
    localparam int COUNT_W      = 4;
    localparam int ADDR_W       = 5;
    localparam int PDATA_W      = 32;
    localparam int REG_IDX_W    = 3;

    localparam logic [CMD_W-1:0] CMD_SIMULATE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TRACK    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE_A  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE_B  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

    localparam logic [REG_IDX_W-1:0] REG_CLAMP_EN    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_INPUT_MIN   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_INPUT_MAX   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OUTPUT_MIN  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_OUTPUT_MAX  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DELAY_STEPS = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_A_COUNT     = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_B_COUNT     = 3'd7;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic [CMD_W-1:0]      cmd;
        sample_t               sample_u;
        sample_t               measured_y;
        logic [COEF_IDX_W-1:0] coef_index;
        sample_t               coef_value;
    } req_t;

    typedef struct packed {
        sample_t y_out;
        sample_t u_applied;
    } rsp_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MAC    = 6'b000010,
        ST_FLUSH  = 6'b000100,
        ST_FIN    = 6'b001000,
        ST_CLAMP  = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    // an upper limit below the lower one collapses onto the lower one
    function automatic sample_t clamp_sample(sample_t v, sample_t lo, sample_t hi);
        sample_t hi_eff;
        hi_eff = (hi < lo) ? lo : hi;
        if (v > hi_eff)
            return hi_eff;
        else if (v < lo)
            return lo;
        else
            return v;
    endfunction

endpackage

// ----- design/arx_model_step.sv -----
// channel   direction  handshake               payload
// req       in         req_valid / req_ready   arx_pkg::req_t
// rsp       out        rsp_valid / rsp_ready   arx_pkg::rsp_t
// apb       in         psel penable pwrite     paddr pwdata -> prdata, pready
//
// simulate item: the MAC state runs over the nb b taps and then the na a taps (nb, na are the
// saturated coefficient counts), then FLUSH, FIN, CLAMP and RESULT; the single 32x32 multiplier takes one tap a cycle.
// track, coefficient write, clear and unknown commands go from IDLE straight to RESULT.
// rst_n clears every history, coefficient and configuration register (delay steps to 1) at once; no sweep follows.
// req_ready is low while an item is at work; a result waiting in the output register
// does not block acceptance, only the loading of the next result.
module arx_model_step (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  arx_pkg::req_t                req,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output arx_pkg::rsp_t                rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [arx_pkg::ADDR_W-1:0]   paddr,
    input  logic [arx_pkg::PDATA_W-1:0]  pwdata,
    output logic [arx_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import arx_pkg::*;

    // configuration
    logic [CLAMP_EN_W-1:0] clamp_en_reg;
    sample_t               in_min_reg;
    sample_t               in_max_reg;
    sample_t               out_min_reg;
    sample_t               out_max_reg;
    logic [DELAY_W-1:0]    delay_steps_reg;
    logic [COUNT_W-1:0]    a_count_reg;
    logic [COUNT_W-1:0]    b_count_reg;

    // model state
    sample_t delay_line_reg [MAX_DELAY];
    sample_t in_hist_reg    [MAX_B_TAPS];
    sample_t out_hist_reg   [MAX_A_TAPS];
    sample_t a_coef_reg     [MAX_A_TAPS];
    sample_t b_coef_reg     [MAX_B_TAPS];
    sample_t last_input_reg;

    // sequencer and datapath
    state_t                      state_reg, state_next;
    logic [TAP_CNT_W-1:0]        tap_reg, tap_next;
    logic                        phase_a_reg, phase_a_next;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    logic                        prod_valid_reg, prod_valid_next;
    logic                        prod_sub_reg, prod_sub_next;
    logic signed [ACC_W-1:0]     acc_reg, acc_next;
    sample_t                     y_sat_reg, y_sat_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    rsp_t                        rsp_reg;

    logic                        req_fire;
    logic                        cfg_write;
    logic [REG_IDX_W-1:0]        reg_idx;
    logic [TAP_CNT_W-1:0]        na, nb;
    logic [TAP_CNT_W-1:0]        tap_inc;
    logic                        tap_last;
    logic [DL_IDX_W-1:0]         dl_sel;
    sample_t                     u_clamped;
    sample_t                     u_push;
    logic                        do_push_u;
    logic                        do_push_y;
    sample_t                     y_push;
    logic                        do_clear;
    sample_t                     sel_coef;
    sample_t                     sel_sample;
    logic signed [ACC_W-1:0]     acc_addend;
    logic signed [SHIFTED_W-1:0] acc_shifted;
    logic                        sat_all_ones;
    logic                        sat_all_zeros;
    logic                        rsp_load;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[ADDR_W-1:2];

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_CLAMP_EN:    prdata = PDATA_W'(clamp_en_reg);
            REG_INPUT_MIN:   prdata = PDATA_W'(in_min_reg);
            REG_INPUT_MAX:   prdata = PDATA_W'(in_max_reg);
            REG_OUTPUT_MIN:  prdata = PDATA_W'(out_min_reg);
            REG_OUTPUT_MAX:  prdata = PDATA_W'(out_max_reg);
            REG_DELAY_STEPS: prdata = PDATA_W'(delay_steps_reg);
            REG_A_COUNT:     prdata = PDATA_W'(a_count_reg);
            REG_B_COUNT:     prdata = PDATA_W'(b_count_reg);
            default:         prdata = '0;
        endcase
    end

    // counts above the tap storage saturate
    assign na = (int'(a_count_reg) > MAX_A_TAPS) ? TAP_CNT_W'(MAX_A_TAPS)
                                                 : TAP_CNT_W'(a_count_reg);
    assign nb = (int'(b_count_reg) > MAX_B_TAPS) ? TAP_CNT_W'(MAX_B_TAPS)
                                                 : TAP_CNT_W'(b_count_reg);

    // tap of the delay line that leaves it, delay zero acts as one
    always_comb
    begin
        if (delay_steps_reg == '0)
            dl_sel = '0;
        else if (int'(delay_steps_reg) > MAX_DELAY)
            dl_sel = DL_IDX_W'(MAX_DELAY - 1);
        else
            dl_sel = DL_IDX_W'(delay_steps_reg - DELAY_W'(1));
    end

    assign u_clamped = clamp_en_reg[0] ? clamp_sample(req.sample_u, in_min_reg, in_max_reg)
                                       : req.sample_u;
    assign u_push    = (req.cmd == CMD_SIMULATE) ? u_clamped : req.sample_u;
    assign do_push_u = req_fire && ((req.cmd == CMD_SIMULATE) || (req.cmd == CMD_TRACK));
    assign do_clear  = req_fire && (req.cmd == CMD_CLEAR);

    always_comb
    begin
        do_push_y = 1'b0;
        y_push    = req.measured_y;
        if (req_fire && (req.cmd == CMD_TRACK))
        begin
            do_push_y = 1'b1;
        end
        else if (state_reg == ST_CLAMP)
        begin
            do_push_y = 1'b1;
            y_push    = clamp_en_reg[1] ? clamp_sample(y_sat_reg, out_min_reg, out_max_reg)
                                        : y_sat_reg;
        end
    end

    // shared multiplier operands: b taps first, then a taps
    always_comb
    begin
        if (phase_a_reg)
        begin
            sel_coef   = a_coef_reg[tap_reg[A_IDX_W-1:0]];
            sel_sample = out_hist_reg[tap_reg[A_IDX_W-1:0]];
        end
        else
        begin
            sel_coef   = b_coef_reg[tap_reg[B_IDX_W-1:0]];
            sel_sample = in_hist_reg[tap_reg[B_IDX_W-1:0]];
        end
    end

    assign tap_inc  = TAP_CNT_W'(tap_reg + TAP_CNT_W'(1));
    assign tap_last = (tap_inc == (phase_a_reg ? na : nb));

    always_comb
    begin
        if (!prod_valid_reg)
            acc_addend = '0;
        else if (prod_sub_reg)
            acc_addend = -ACC_W'(prod_reg);
        else
            acc_addend = ACC_W'(prod_reg);
    end

    // floor of the exact sum, then saturation to the sample width
    assign acc_shifted   = SHIFTED_W'(acc_reg >>> FRAC_BITS);
    assign sat_all_ones  = &acc_shifted[SHIFTED_W-1:SAMPLE_W-1];
    assign sat_all_zeros = ~|acc_shifted[SHIFTED_W-1:SAMPLE_W-1];

    always_comb
    begin
        if (sat_all_ones || sat_all_zeros)
            y_sat_next = acc_shifted[SAMPLE_W-1:0];
        else if (acc_shifted[SHIFTED_W-1])
            y_sat_next = {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            y_sat_next = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end

    assign rsp_load = (state_reg == ST_RESULT) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        state_next      = state_reg;
        tap_next        = tap_reg;
        phase_a_next    = phase_a_reg;
        prod_next       = prod_reg;
        prod_valid_next = 1'b0;
        prod_sub_next   = prod_sub_reg;
        acc_next        = acc_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    acc_next = '0;
                    tap_next = '0;
                    if (req.cmd != CMD_SIMULATE)
                        state_next = ST_RESULT;
                    else if (nb != '0)
                    begin
                        phase_a_next = 1'b0;
                        state_next   = ST_MAC;
                    end
                    else if (na != '0)
                    begin
                        phase_a_next = 1'b1;
                        state_next   = ST_MAC;
                    end
                    else
                        state_next = ST_FLUSH;
                end
            end
            ST_MAC:
            begin
                // multiply this tap while the previous product is accumulated
                prod_next       = sel_coef * sel_sample;
                prod_valid_next = 1'b1;
                prod_sub_next   = phase_a_reg;
                acc_next        = acc_reg + acc_addend;
                if (!tap_last)
                    tap_next = tap_inc;
                else if (!phase_a_reg && (na != '0))
                begin
                    phase_a_next = 1'b1;
                    tap_next     = '0;
                end
                else
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                acc_next   = acc_reg + acc_addend;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (rsp_load)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tap_reg        <= '0;
            phase_a_reg    <= 1'b0;
            prod_valid_reg <= 1'b0;
            prod_sub_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tap_reg        <= tap_next;
            phase_a_reg    <= phase_a_next;
            prod_valid_reg <= prod_valid_next;
            prod_sub_reg   <= prod_sub_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (state_reg == ST_FIN)
            y_sat_reg <= y_sat_next;
        if (rsp_load)
        begin
            rsp_reg.y_out     <= out_hist_reg[0];
            rsp_reg.u_applied <= last_input_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_en_reg    <= '0;
            in_min_reg      <= '0;
            in_max_reg      <= '0;
            out_min_reg     <= '0;
            out_max_reg     <= '0;
            delay_steps_reg <= DELAY_W'(1);
            a_count_reg     <= '0;
            b_count_reg     <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_CLAMP_EN:    clamp_en_reg    <= pwdata[CLAMP_EN_W-1:0];
                REG_INPUT_MIN:   in_min_reg      <= pwdata[SAMPLE_W-1:0];
                REG_INPUT_MAX:   in_max_reg      <= pwdata[SAMPLE_W-1:0];
                REG_OUTPUT_MIN:  out_min_reg     <= pwdata[SAMPLE_W-1:0];
                REG_OUTPUT_MAX:  out_max_reg     <= pwdata[SAMPLE_W-1:0];
                REG_DELAY_STEPS: delay_steps_reg <= pwdata[DELAY_W-1:0];
                REG_A_COUNT:     a_count_reg     <= pwdata[COUNT_W-1:0];
                REG_B_COUNT:     b_count_reg     <= pwdata[COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_DELAY; i++)
                delay_line_reg[i] <= '0;
            for (int i = 0; i < MAX_B_TAPS; i++)
            begin
                in_hist_reg[i] <= '0;
                b_coef_reg[i]  <= '0;
            end
            for (int i = 0; i < MAX_A_TAPS; i++)
            begin
                out_hist_reg[i] <= '0;
                a_coef_reg[i]   <= '0;
            end
            last_input_reg <= '0;
        end
        else
        begin
            if (do_clear)
            begin
                for (int i = 0; i < MAX_DELAY; i++)
                    delay_line_reg[i] <= '0;
                for (int i = 0; i < MAX_B_TAPS; i++)
                    in_hist_reg[i] <= '0;
                for (int i = 0; i < MAX_A_TAPS; i++)
                    out_hist_reg[i] <= '0;
            end
            if (do_push_u)
            begin
                last_input_reg <= u_push;
                for (int i = MAX_DELAY - 1; i > 0; i--)
                    delay_line_reg[i] <= delay_line_reg[i-1];
                delay_line_reg[0] <= u_push;
                for (int i = MAX_B_TAPS - 1; i > 0; i--)
                    in_hist_reg[i] <= in_hist_reg[i-1];
                in_hist_reg[0] <= delay_line_reg[dl_sel];
            end
            if (do_push_y)
            begin
                for (int i = MAX_A_TAPS - 1; i > 0; i--)
                    out_hist_reg[i] <= out_hist_reg[i-1];
                out_hist_reg[0] <= y_push;
            end
            if (req_fire && (req.cmd == CMD_WRITE_A) && (int'(req.coef_index) < MAX_A_TAPS))
                a_coef_reg[A_IDX_W'(req.coef_index)] <= req.coef_value;
            if (req_fire && (req.cmd == CMD_WRITE_B) && (int'(req.coef_index) < MAX_B_TAPS))
                b_coef_reg[B_IDX_W'(req.coef_index)] <= req.coef_value;
        end
    end

endmodule
